>>> rtl/swmm_pkg.sv
package swmm_pkg;

    localparam int WIN_MAX  = 256;
    localparam int IDX_W    = $clog2(WIN_MAX);
    localparam int WLEN_W   = IDX_W + 1;
    localparam int SAMPLE_W = 32;
    localparam int POS_W    = 16;
    localparam int ENTRY_W  = SAMPLE_W + POS_W;
    localparam int MEM_AW   = IDX_W + 1;

    localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(16);
    localparam logic [WLEN_W-1:0] WLEN_MAX   = WLEN_W'(WIN_MAX);

    localparam logic RING_MIN = 1'b0;
    localparam logic RING_MAX = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START_MAX,
        S_HEAD_CHK,
        S_HEAD_CMP,
        S_WALK,
        S_OUT
    } t_state;

    // Advance a ring index, wrapping at the window length.
    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i,
                                                  input logic [WLEN_W-1:0] k);
        logic [WLEN_W-1:0] inc;
        inc = {1'b0, i} + WLEN_W'(1);
        return (inc >= k) ? '0 : inc[IDX_W-1:0];
    endfunction

    // Step a ring index back; indices beyond the window land on its last slot.
    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i,
                                                  input logic [WLEN_W-1:0] k);
        logic [WLEN_W-1:0] last;
        last = k - WLEN_W'(1);
        return (i == '0 || {1'b0, i} > k) ? last[IDX_W-1:0] : i - IDX_W'(1);
    endfunction

endpackage

>>> rtl/sliding_window_min_max_core.sv
// Channel   Direction  Handshake                     Payload
// input     in         i_valid / o_ready             i_sample, i_first_of_series
// result    out        o_valid / i_ready             o_min_value, o_max_value
// config    in         i_cfg_valid / o_cfg_ready     i_cfg_window_len
//
// A series start runs through accept, second ring write and output load.
// Any other sample runs each ring in turn: it reads its head (plus one more
// read when the head expires) and then reads entries on the backward walk,
// one entry per cycle through the single read port of the shared ring
// memory.
// Synchronous active-low reset clears pointers, position and window length (16);
// ring contents are not cleared. A stalled result holds in the output register
// while the next sample is accepted; a finished sample waits in S_OUT for it.
module sliding_window_min_max_core
    import swmm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_first_of_series,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [SAMPLE_W-1:0] o_min_value,
    output logic signed [SAMPLE_W-1:0] o_max_value,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [WLEN_W-1:0]          i_cfg_window_len
);

    localparam logic [SAMPLE_W-1:0] SIGN_BIT = {1'b1, {(SAMPLE_W-1){1'b0}}};

    t_state r_state, n_state;

    logic [WLEN_W-1:0]   r_wlen;
    logic [POS_W-1:0]    r_spos, n_spos;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [SAMPLE_W-1:0] r_key, n_key;
    logic [WLEN_W-1:0]   r_k, n_k;
    logic                r_sel, n_sel;
    logic [IDX_W-1:0]    r_head [0:1];
    logic [IDX_W-1:0]    n_head [0:1];
    logic [IDX_W-1:0]    r_tail [0:1];
    logic [IDX_W-1:0]    n_tail [0:1];
    logic [WLEN_W-1:0]   r_steps, n_steps;
    logic [SAMPLE_W-1:0] r_head_val, n_head_val;
    logic [SAMPLE_W-1:0] r_res_min, n_res_min;
    logic [SAMPLE_W-1:0] r_res_max, n_res_max;
    logic                r_o_valid, n_o_valid;
    logic [SAMPLE_W-1:0] r_o_min, n_o_min;
    logic [SAMPLE_W-1:0] r_o_max, n_o_max;

    // ring memory: both rings, ring select in the top address bit
    logic [ENTRY_W-1:0]  r_mem [0:(1<<MEM_AW)-1];
    logic [ENTRY_W-1:0]  r_rd;
    logic                mem_we;
    logic [MEM_AW-1:0]   mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic [MEM_AW-1:0]   mem_raddr;

    logic [SAMPLE_W-1:0] rd_val;
    logic [POS_W-1:0]    rd_exp;
    logic [SAMPLE_W-1:0] in_key;
    logic [SAMPLE_W-1:0] key_sel;
    logic [POS_W-1:0]    death;
    logic [IDX_W-1:0]    head, tail, head_nx, tail_pv, app_base, app_idx;
    logic [WLEN_W-1:0]   steps_n;
    logic                accept, expired, decide, cmp_le, replace;
    logic                walk_go, walk_more, append, ring_done, out_load;

    assign rd_val  = r_rd[ENTRY_W-1:POS_W];
    assign rd_exp  = r_rd[POS_W-1:0];
    assign in_key  = i_sample ^ SIGN_BIT;
    assign accept  = i_valid && o_ready;

    // shared compare unit: new key against the entry just read
    assign key_sel = (r_sel == RING_MAX) ? ~r_key : r_key;
    assign cmp_le  = key_sel <= rd_val;
    assign death   = r_pos + POS_W'(r_k);

    assign head    = r_head[r_sel];
    assign tail    = r_tail[r_sel];
    assign head_nx = idx_next(head, r_k);
    assign tail_pv = idx_prev(tail, r_k);
    assign steps_n = r_steps + WLEN_W'(1);

    assign expired   = (r_state == S_HEAD_CHK) && (rd_exp == r_pos);
    assign decide    = (r_state == S_HEAD_CMP) || ((r_state == S_HEAD_CHK) && !expired);
    assign replace   = decide && cmp_le;
    assign walk_go   = (r_state == S_WALK) && cmp_le;
    assign walk_more = walk_go && (tail_pv != head) && (steps_n < WLEN_MAX);
    assign append    = (decide && !cmp_le && (tail == head))
                    || ((r_state == S_WALK) && !walk_more);
    assign ring_done = replace || append;
    assign app_base  = walk_go ? tail_pv : tail;
    assign app_idx   = idx_next(app_base, r_k);
    assign out_load  = (r_state == S_OUT) && (!r_o_valid || i_ready);

    logic [WLEN_W-1:0] wlen_sat;
    always_comb begin
        if (r_wlen == '0) begin
            wlen_sat = WLEN_W'(1);
        end else if (r_wlen > WLEN_MAX) begin
            wlen_sat = WLEN_MAX;
        end else begin
            wlen_sat = r_wlen;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = i_first_of_series ? S_START_MAX : S_HEAD_CHK;
                end
            end
            S_START_MAX: begin
                n_state = S_OUT;
            end
            S_HEAD_CHK, S_HEAD_CMP: begin
                if (expired) begin
                    n_state = S_HEAD_CMP;
                end else if (ring_done) begin
                    n_state = (r_sel == RING_MAX) ? S_OUT : S_HEAD_CHK;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (!walk_more) begin
                    n_state = (r_sel == RING_MAX) ? S_OUT : S_HEAD_CHK;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory port control
    always_comb begin
        logic [SAMPLE_W-1:0] ring_res;
        n_spos     = r_spos;
        n_pos      = r_pos;
        n_key      = r_key;
        n_k        = r_k;
        n_sel      = r_sel;
        n_head     = r_head;
        n_tail     = r_tail;
        n_steps    = r_steps;
        n_head_val = r_head_val;
        n_res_min  = r_res_min;
        n_res_max  = r_res_max;
        n_o_valid  = r_o_valid && !i_ready;
        n_o_min    = r_o_min;
        n_o_max    = r_o_max;
        mem_we     = 1'b0;
        mem_waddr  = {r_sel, head};
        mem_wdata  = {key_sel, death};
        mem_raddr  = {r_sel, head};
        ring_res   = key_sel;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_key   = in_key;
                    n_k     = wlen_sat;
                    n_pos   = i_first_of_series ? '0 : r_spos;
                    n_spos  = n_pos + POS_W'(1);
                    n_steps = '0;
                    if (i_first_of_series) begin
                        n_sel     = RING_MAX;
                        n_head[0] = '0;
                        n_head[1] = '0;
                        n_tail[0] = '0;
                        n_tail[1] = '0;
                        n_res_min = in_key;
                        n_res_max = ~in_key;
                        mem_we    = 1'b1;
                        mem_waddr = {RING_MIN, IDX_W'(0)};
                        mem_wdata = {in_key, POS_W'(wlen_sat)};
                    end else begin
                        n_sel     = RING_MIN;
                        mem_raddr = {RING_MIN, r_head[0]};
                    end
                end
            end
            S_START_MAX: begin
                mem_we    = 1'b1;
                mem_waddr = {RING_MAX, IDX_W'(0)};
                mem_wdata = {~r_key, POS_W'(r_k)};
            end
            S_HEAD_CHK, S_HEAD_CMP, S_WALK: begin
                if (expired) begin
                    // drop the expired head, fetch the next one
                    n_head[r_sel] = head_nx;
                    mem_raddr     = {r_sel, head_nx};
                end else if (replace) begin
                    mem_we        = 1'b1;
                    mem_waddr     = {r_sel, head};
                    n_tail[r_sel] = head;
                    ring_res      = key_sel;
                end else begin
                    if (decide) begin
                        n_head_val = rd_val;
                        n_steps    = '0;
                        mem_raddr  = {r_sel, tail};
                    end
                    if (walk_go) begin
                        n_tail[r_sel] = tail_pv;
                        n_steps       = steps_n;
                        mem_raddr     = {r_sel, tail_pv};
                    end
                    if (append) begin
                        mem_we        = 1'b1;
                        mem_waddr     = {r_sel, app_idx};
                        n_tail[r_sel] = app_idx;
                        // the head survives unless the append landed on it
                        ring_res = (app_idx == head) ? key_sel
                                 : (decide ? rd_val : r_head_val);
                    end
                end
                if (ring_done) begin
                    if (r_sel == RING_MIN) begin
                        n_res_min = ring_res;
                        n_sel     = RING_MAX;
                        mem_raddr = {RING_MAX, r_head[1]};
                    end else begin
                        n_res_max = ring_res;
                    end
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_o_valid = 1'b1;
                    n_o_min   = r_res_min ^ SIGN_BIT;
                    n_o_max   = ~r_res_max ^ SIGN_BIT;
                end
            end
            default: begin
                n_sel = RING_MIN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wlen    <= WLEN_RESET;
            r_spos    <= '0;
            r_sel     <= RING_MIN;
            r_head[0] <= '0;
            r_head[1] <= '0;
            r_tail[0] <= '0;
            r_tail[1] <= '0;
            r_steps   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_wlen <= i_cfg_window_len;
            end
            r_spos    <= n_spos;
            r_sel     <= n_sel;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_steps   <= n_steps;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_key      <= n_key;
        r_k        <= n_k;
        r_head_val <= n_head_val;
        r_res_min  <= n_res_min;
        r_res_max  <= n_res_max;
        r_o_min    <= n_o_min;
        r_o_max    <= n_o_max;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_o_valid;
    assign o_min_value = r_o_min;
    assign o_max_value = r_o_max;

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> r_steps < WLEN_MAX)
        else $error("backward walk ran past its bound");

    a_walk_short_of_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> r_tail[r_sel] != r_head[r_sel])
        else $error("backward walk reached the head");

    a_series_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_first_of_series)
            |=> r_state == S_START_MAX ##1 r_state == S_OUT)
        else $error("series start did not finish in two cycles");

    a_out_after_both_rings: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> r_sel == RING_MAX)
        else $error("result loaded before the max ring finished");

    a_busy_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !accept) |-> !mem_we)
        else $error("ring memory written while idle");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import swmm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 16;
    localparam logic [SAMPLE_W-1:0] SIGN_BIT = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] MOST_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] MOST_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};

    typedef enum int {
        PACE_FULL,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } t_pace;

    // Tracks the running min and max rings and queues the values each sample should yield.
    class window_extremes_scoreboard;
        bit [SAMPLE_W-1:0] ring_key     [2][WIN_MAX];
        bit [POS_W-1:0]    ring_expiry  [2][WIN_MAX];
        bit                ring_written [2][WIN_MAX];
        int                ring_head    [2];
        int                ring_tail    [2];
        bit [WLEN_W-1:0]   window_reg;
        bit [POS_W-1:0]    next_pos;
        logic signed [SAMPLE_W-1:0] min_due [$];
        logic signed [SAMPLE_W-1:0] max_due [$];
        int mismatches;
        int samples_seen;
        int series_starts;
        int results_seen;

        function new();
            window_reg    = WLEN_RESET;
            next_pos      = '0;
            ring_head     = '{0, 0};
            ring_tail     = '{0, 0};
            mismatches    = 0;
            samples_seen  = 0;
            series_starts = 0;
            results_seen  = 0;
        endfunction

        task report(input string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            mismatches++;
        endtask

        function void set_window(input bit [WLEN_W-1:0] wlen);
            window_reg = wlen;
        endfunction

        function int pending();
            return min_due.size();
        endfunction

        // Zero acts as one; anything past the ring depth saturates.
        function int window_span();
            int k;
            k = int'(window_reg);
            if (k == 0) k = 1;
            if (k > WIN_MAX) k = WIN_MAX;
            return k;
        endfunction

        function int step_fwd(input int i, input int k);
            return (i + 1 >= k) ? 0 : i + 1;
        endfunction

        function int step_back(input int i, input int k);
            return (i == 0 || i > k) ? k - 1 : i - 1;
        endfunction

        function void ring_restart(input int r, input bit [SAMPLE_W-1:0] key, input int k);
            ring_head[r]       = 0;
            ring_tail[r]       = 0;
            ring_key[r][0]     = key;
            ring_expiry[r][0]  = POS_W'(k);
            ring_written[r][0] = 1'b1;
        endfunction

        // Push one key; with commit low only report whether an unwritten slot would be read.
        function bit ring_push(input int r, input bit [SAMPLE_W-1:0] key,
                               input bit [POS_W-1:0] pos, input int k, input bit commit);
            int h;
            int t;
            int steps;
            bit [POS_W-1:0] death;
            bit blind;
            h     = ring_head[r];
            t     = ring_tail[r];
            steps = 0;
            death = pos + POS_W'(k);
            blind = !ring_written[r][h];
            if (ring_expiry[r][h] == pos) h = step_fwd(h, k);
            blind |= !ring_written[r][h];
            if (key <= ring_key[r][h]) begin
                t = h;
            end else begin
                while (1) begin
                    if (t == h) break;
                    blind |= !ring_written[r][t];
                    if (ring_key[r][t] < key || steps >= WIN_MAX) break;
                    t = step_back(t, k);
                    steps++;
                end
                t = step_fwd(t, k);
            end
            if (commit) begin
                ring_key[r][t]     = key;
                ring_expiry[r][t]  = death;
                ring_written[r][t] = 1'b1;
                ring_head[r]       = h;
                ring_tail[r]       = t;
            end
            return blind;
        endfunction

        function bit reads_unwritten(input logic signed [SAMPLE_W-1:0] s);
            bit [SAMPLE_W-1:0] key;
            key = s ^ SIGN_BIT;
            return ring_push(RING_MIN, key, next_pos, window_span(), 1'b0)
                 | ring_push(RING_MAX, ~key, next_pos, window_span(), 1'b0);
        endfunction

        function void note_sample(input logic signed [SAMPLE_W-1:0] s, input logic first);
            bit [SAMPLE_W-1:0] key;
            bit [POS_W-1:0] pos;
            int k;
            k   = window_span();
            key = s ^ SIGN_BIT;
            if (first) begin
                pos = '0;
                ring_restart(RING_MIN, key, k);
                ring_restart(RING_MAX, ~key, k);
                series_starts++;
            end else begin
                pos = next_pos;
                void'(ring_push(RING_MIN, key, pos, k, 1'b1));
                void'(ring_push(RING_MAX, ~key, pos, k, 1'b1));
            end
            next_pos = pos + POS_W'(1);
            min_due.push_back(ring_key[RING_MIN][ring_head[RING_MIN]] ^ SIGN_BIT);
            max_due.push_back(~ring_key[RING_MAX][ring_head[RING_MAX]] ^ SIGN_BIT);
            samples_seen++;
        endfunction

        task check_result(input logic signed [SAMPLE_W-1:0] mn,
                          input logic signed [SAMPLE_W-1:0] mx);
            logic signed [SAMPLE_W-1:0] want_min;
            logic signed [SAMPLE_W-1:0] want_max;
            if (min_due.size() == 0) begin
                report($sformatf("result %0d arrived with nothing pending (min %0d max %0d)",
                                 results_seen, mn, mx));
            end else begin
                want_min = min_due.pop_front();
                want_max = max_due.pop_front();
                if (mn !== want_min)
                    report($sformatf("result %0d min_value %0d, want %0d",
                                     results_seen, mn, want_min));
                if (mx !== want_max)
                    report($sformatf("result %0d max_value %0d, want %0d",
                                     results_seen, mx, want_max));
            end
            results_seen++;
        endtask
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       i_first_of_series;
    logic                       o_valid;
    logic                       i_ready;
    logic signed [SAMPLE_W-1:0] o_min_value;
    logic signed [SAMPLE_W-1:0] o_max_value;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [WLEN_W-1:0]          i_cfg_window_len;

    window_extremes_scoreboard sb;
    int send_idle_pct;
    int stall_pct;
    int idle_cycles;
    logic signed [SAMPLE_W-1:0] prev_sample;
    logic signed [SAMPLE_W-1:0] series_base;
    int trend;

    sliding_window_min_max_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_sample         (i_sample),
        .i_first_of_series(i_first_of_series),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_min_value      (o_min_value),
        .o_max_value      (o_max_value),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_window_len (i_cfg_window_len)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_min_value, o_max_value);
    end

    // Count cycles where no channel moves a transaction.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, sb.pending());
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic set_pace(input t_pace pace);
        case (pace)
            PACE_FULL: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            PACE_SEND_IDLE: begin
                send_idle_pct = 59;
                stall_pct     = 0;
            end
            PACE_RECV_STALL: begin
                send_idle_pct = 0;
                stall_pct     = 59;
            end
            default: begin
                send_idle_pct = 29;
                stall_pct     = 29;
            end
        endcase
    endtask

    // Fall back to a series start whenever the sample would hit a never-written ring slot.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic first);
        logic f;
        f = first;
        if (!f && sb.reads_unwritten(s)) f = 1'b1;
        prev_sample = s;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_sample          <= s;
        i_first_of_series <= f;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_sample(s, f);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [WLEN_W-1:0] wlen);
        @(negedge i_clk);
        i_cfg_valid      <= 1'b1;
        i_cfg_window_len <= wlen;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_window(wlen);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(9))
            0: v = $urandom;
            1: begin
                case ($urandom_range(3))
                    0: v = MOST_NEG;
                    1: v = MOST_POS;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            2, 3, 4, 5: v = series_base + $signed(SAMPLE_W'($urandom_range(15))) - 8;
            6, 7: v = prev_sample + trend;
            8: v = prev_sample;
            default: v = prev_sample - 1 + $signed(SAMPLE_W'($urandom_range(2)));
        endcase
        return v;
    endfunction

    task automatic send_random_sample(input bit force_start);
        logic f;
        f = force_start || ($urandom_range(39) == 0);
        if (f) begin
            series_base = $urandom;
            if ($urandom_range(1)) trend = int'($urandom_range(1000));
            else trend = -int'($urandom_range(1000));
        end
        send_sample(pick_sample(), f);
    endtask

    // Keep the series running across the window write unless restart is set.
    task automatic run_phase(input logic [WLEN_W-1:0] wlen, input t_pace pace,
                             input int count, input bit restart, input bit hold_midway);
        wait_drained();
        write_window(wlen);
        set_pace(pace);
        for (int n = 0; n < count; n++) begin
            if (hold_midway && n == count / 2) wait_drained();
            send_random_sample(restart && n == 0);
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_sample          = '0;
        i_first_of_series = 1'b0;
        i_ready           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_window_len  = '0;
        idle_cycles       = 0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        prev_sample       = '0;
        series_base       = '0;
        trend             = 1;
        sb                = new();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window of 16: field extremes and ties.
        send_sample(0, 1'b1);
        send_sample(MOST_POS, 1'b0);
        send_sample(MOST_NEG, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(1, 1'b0);
        send_sample(1, 1'b0);
        send_sample(5, 1'b1);

        // Window of two: head expiry on both rings.
        wait_drained();
        write_window(WLEN_W'(2));
        send_sample(10, 1'b1);
        send_sample(20, 1'b0);
        send_sample(30, 1'b0);
        send_sample(5, 1'b0);
        send_sample(5, 1'b0);
        send_sample(40, 1'b0);
        send_sample(15, 1'b0);

        // Zero behaves as one.
        wait_drained();
        write_window('0);
        send_sample(3, 1'b1);
        send_sample(7, 1'b0);
        send_sample(-2, 1'b0);
        send_sample(7, 1'b0);

        // All ones saturates to the full ring.
        wait_drained();
        write_window('1);
        send_sample(1, 1'b1);
        send_sample(2, 1'b0);
        send_sample(3, 1'b0);

        run_phase(WLEN_W'(1), PACE_FULL, 55, 1'b1, 1'b0);
        run_phase(WLEN_MAX, PACE_SEND_IDLE, 70, 1'b1, 1'b1);
        run_phase(WLEN_W'(5), PACE_RECV_STALL, 60, 1'b0, 1'b0);
        run_phase(WLEN_W'(300), PACE_BOTH, 60, 1'b0, 1'b0);
        run_phase(WLEN_W'(3), PACE_FULL, 60, 1'b1, 1'b0);
        run_phase(WLEN_W'($urandom_range(WIN_MAX, 1)), PACE_SEND_IDLE, 60, 1'b0, 1'b0);
        run_phase('0, PACE_RECV_STALL, 50, 1'b0, 1'b0);
        run_phase(WLEN_RESET, PACE_BOTH, 70, 1'b1, 1'b0);
        run_phase(WLEN_W'($urandom), PACE_FULL, 60, 1'b0, 1'b0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d samples in %0d series, %0d results compared",
                 sb.samples_seen, sb.series_starts, sb.results_seen);
        $display("windows 0, 1, 2, 3, 5, 16, 256, saturated and random, some changed mid-series");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/swmm_pkg.sv
rtl/sliding_window_min_max_core.sv
tb/testbench.sv
